FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expects clk and rst (synchronous, active high) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

FILE: hdl/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg
// Command codes and RGB565 helper functions for the wheel color fader.
// ----------------------------------------------------------------------------
`default_nettype none

package rcf_pkg;

  typedef enum logic [1:0] {
    CMD_STEP   = 2'd0,
    CMD_WHEEL  = 2'd1,
    CMD_TARGET = 2'd2,
    CMD_LOAD   = 2'd3
  } rcf_cmd_t;

  localparam logic [6:0] WHEEL_LAST = 7'd95;
  localparam logic [4:0] CHAN_MAX   = 5'h1f;

  function automatic logic [15:0] pack565(input logic [4:0] r, input logic [5:0] g,
                                          input logic [4:0] b);
    return {r, g, b};
  endfunction

  // Three 32-step segments; positions past the wheel end clamp to its last step.
  function automatic logic [15:0] wheel_color(input logic [6:0] pos);
    logic [6:0] p;
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    p = (pos > WHEEL_LAST) ? WHEEL_LAST : pos;
    case (p[6:5])
      2'd0: begin
        r = 5'd0;
        g = p[4:0];
        b = CHAN_MAX - p[4:0];
      end
      2'd1: begin
        r = p[4:0];
        g = CHAN_MAX - p[4:0];
        b = 5'd0;
      end
      default: begin
        r = CHAN_MAX - p[4:0];
        g = 5'd0;
        b = p[4:0];
      end
    endcase
    return pack565(r, {g, 1'b0}, b);
  endfunction

  function automatic logic [4:0] step_one(input logic [4:0] v, input logic [4:0] t);
    logic [4:0] res;
    if (v > t) begin
      res = v - 5'd1;
    end else if (v < t) begin
      res = v + 5'd1;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Move green two units, but only when more than one unit away.
  function automatic logic [5:0] step_green(input logic [5:0] v, input logic [5:0] t);
    logic [6:0] v7;
    logic [6:0] t7;
    logic [5:0] res;
    v7 = {1'b0, v};
    t7 = {1'b0, t};
    if (v7 > t7 + 7'd1) begin
      res = v - 6'd2;
    end else if (v7 + 7'd1 < t7) begin
      res = v + 6'd2;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rgb565_wheel_color_fader.sv
// Step items go from the input register to the result register. Throughput:
// one item per cycle unless a step item waits on out_stall; an input register
// feeds one pass of compare and step logic on the color registers, which loads
// the result register. Commands other than a step update state, give no result.
// Reset (rst, synchronous) clears current and target colors and all valids.
// ----------------------------------------------------------------------------
// rgb565_wheel_color_fader
// Holds a current and target RGB565 color, fades current toward target one
// step per step item and emits full, half and quarter brightness results.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_wheel_color_fader
  import rcf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [6:0]  wheel_pos,
  input  wire logic [15:0] new_color,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      color_full,
  output logic [15:0]      color_dim,
  output logic [15:0]      color_quarter
);

  `include "assert_macros.svh"

  // input register
  logic        s1_valid;
  rcf_cmd_t    s1_cmd;
  logic [6:0]  s1_pos;
  logic [15:0] s1_color;

  logic [15:0] current_rgb;
  logic [15:0] current_rgb_next;
  logic [15:0] target_rgb;
  logic [15:0] target_rgb_next;

  logic out_free;
  logic s1_adv;
  logic in_take;
  logic out_load;

  logic [4:0] r_next;
  logic [5:0] g_next;
  logic [4:0] b_next;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && ((s1_cmd != CMD_STEP) || out_free);
  assign out_load = s1_adv && (s1_cmd == CMD_STEP);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign r_next = step_one(current_rgb[15:11], target_rgb[15:11]);
  assign g_next = step_green(current_rgb[10:5], target_rgb[10:5]);
  assign b_next = step_one(current_rgb[4:0], target_rgb[4:0]);

  always_comb begin
    current_rgb_next = current_rgb;
    target_rgb_next  = target_rgb;
    if (s1_adv) begin
      case (s1_cmd)
        CMD_STEP:   current_rgb_next = pack565(r_next, g_next, b_next);
        CMD_WHEEL:  target_rgb_next  = wheel_color(s1_pos);
        CMD_TARGET: target_rgb_next  = s1_color;
        CMD_LOAD:   current_rgb_next = s1_color;
        default:    current_rgb_next = current_rgb;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      current_rgb <= '0;
      target_rgb  <= '0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      current_rgb <= current_rgb_next;
      target_rgb  <= target_rgb_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd   <= rcf_cmd_t'(cmd);
      s1_pos   <= wheel_pos;
      s1_color <= new_color;
    end
    if (out_load) begin
      color_full    <= pack565(r_next, g_next, b_next);
      color_dim     <= pack565({1'b0, r_next[4:1]}, {1'b0, g_next[5:1]},
                               {1'b0, b_next[4:1]});
      color_quarter <= pack565({2'b00, r_next[4:2]}, {2'b00, g_next[5:2]},
                               {2'b00, b_next[4:2]});
    end
  end

  `ASSERT_ALWAYS(a_stall_only_on_step,
                 !in_stall || (s1_valid && s1_cmd == CMD_STEP && out_valid),
                 "input stalled without a blocked step item")
  `ASSERT_ALWAYS(a_result_from_step,
                 !$rose(out_valid) || $past(out_load),
                 "result appeared without a step item")
  `ASSERT_NEXT(a_full_tracks_current, out_load, color_full == current_rgb,
               "full color differs from current color after a step")
  `ASSERT_NEXT(a_load_sets_current, s1_adv && s1_cmd == CMD_LOAD,
               current_rgb == $past(s1_color),
               "load item did not set the current color")

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RGB565 wheel color fader: a driver streams
// command items from a queue, a shadow fader predicts each step's full, half
// and quarter colors, and a monitor checks the results under random stalls.
// ----------------------------------------------------------------------------
module tb;
  import rcf_pkg::*;

  localparam int DIRECTED_LEN = 25;
  localparam int RANDOM_LEN   = 1125;
  localparam int QUIET_TAIL   = 100;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    rcf_cmd_t    op;
    logic [6:0]  pos;
    logic [15:0] color;
  } fade_item_t;

  typedef struct packed {
    logic [15:0] full;
    logic [15:0] half;
    logic [15:0] quarter;
  } shades_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_STEP;
  logic [6:0]  wheel_pos = '0;
  logic [15:0] new_color = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] color_full;
  logic [15:0] color_dim;
  logic [15:0] color_quarter;

  fade_item_t  pending_cmds[$];
  shades_t     expected_shades[$];
  fade_item_t  item_on_bus;
  logic [15:0] cur_color = '0;
  logic [15:0] tgt_color = '0;
  logic        calm = 1'b0;
  int          failures = 0;
  int          cycles = 0;
  int          idle_left = 0;
  int          idle_pct = 0;
  int          accepted = 0;
  int          stall_left = 0;
  int          stall_pct = 0;

  rgb565_wheel_color_fader dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .wheel_pos     (wheel_pos),
    .new_color     (new_color),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .color_full    (color_full),
    .color_dim     (color_dim),
    .color_quarter (color_quarter)
  );

  always #6 clk = ~clk;

  function automatic logic [15:0] rgb(input int r, input int g, input int b);
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  function automatic logic [15:0] wheel_target(input logic [6:0] pos);
    int p;
    p = (pos > 7'd95) ? 95 : int'(pos);
    if (p < 32) begin
      return rgb(0, 2 * p, 31 - p);
    end else if (p < 64) begin
      return rgb(p - 32, 2 * (63 - p), 0);
    end
    return rgb(95 - p, 0, p - 64);
  endfunction

  function automatic int toward(input int v, input int t);
    if (v > t) begin
      return v - 1;
    end else if (v < t) begin
      return v + 1;
    end
    return v;
  endfunction

  // Update the shadow colors; return 1 when the item yields a result.
  function automatic bit apply_fader_cmd(input fade_item_t it, output shades_t res);
    int r, g, b, tr, tg, tb;
    res = '0;
    case (it.op)
      CMD_WHEEL: begin
        tgt_color = wheel_target(it.pos);
        return 1'b0;
      end
      CMD_TARGET: begin
        tgt_color = it.color;
        return 1'b0;
      end
      CMD_LOAD: begin
        cur_color = it.color;
        return 1'b0;
      end
      default: begin
      end
    endcase
    r  = int'(cur_color[15:11]);
    g  = int'(cur_color[10:5]);
    b  = int'(cur_color[4:0]);
    tr = int'(tgt_color[15:11]);
    tg = int'(tgt_color[10:5]);
    tb = int'(tgt_color[4:0]);
    r = toward(r, tr);
    b = toward(b, tb);
    // green jumps by two and holds when within one unit
    if (g > tg + 1) begin
      g = g - 2;
    end else if (g + 1 < tg) begin
      g = g + 2;
    end
    cur_color   = rgb(r, g, b);
    res.full    = cur_color;
    res.half    = rgb(r >> 1, g >> 1, b >> 1);
    res.quarter = rgb(r >> 2, g >> 2, b >> 2);
    return 1'b1;
  endfunction

  function automatic fade_item_t mk(input rcf_cmd_t op, input int pos, input int col);
    fade_item_t it;
    it.op    = op;
    it.pos   = pos[6:0];
    it.color = col[15:0];
    return it;
  endfunction

  function automatic int rand_color();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 16'hffff;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= 10) begin
      $display("MISMATCH at cycle %0d: %s", cycles, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      log_failure($sformatf("%s expected %h got %h", name, want, got));
    end
  endtask

  // Driver: hold the item while stalled, otherwise advance or idle.
  always @(posedge clk) begin
    shades_t res;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        if (apply_fader_cmd(item_on_bus, res)) begin
          expected_shades.push_back(res);
        end
        accepted++;
        if (accepted % 64 == 0) begin
          case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 10;
            default: idle_pct = 35;
          endcase
        end
      end
      calm <= (pending_cmds.size() < QUIET_TAIL);
      if (idle_left > 0 && !calm) begin
        idle_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        idle_left = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else begin
        idle_left = 0;
        item_on_bus = pending_cmds.pop_front();
        cmd       <= item_on_bus.op;
        wheel_pos <= item_on_bus.pos;
        new_color <= item_on_bus.color;
        in_valid  <= 1'b1;
      end
    end
  end

  // Monitor: check each accepted result, then pick the next stall.
  always @(posedge clk) begin
    shades_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_shades.size() == 0) begin
          log_failure($sformatf("unexpected result %h %h %h",
                                color_full, color_dim, color_quarter));
        end else begin
          want = expected_shades.pop_front();
          check_field("color_full", want.full, color_full);
          check_field("color_dim", want.half, color_dim);
          check_field("color_quarter", want.quarter, color_quarter);
        end
      end
      if (cycles % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
      if (calm) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rgb565_wheel_color_fader test failed");
      $finish;
    end
  end

  initial begin
    int nsteps;
    int target_len;
    // fresh state, full swing down, then back up
    pending_cmds.push_back(mk(CMD_STEP, 0, 0));
    pending_cmds.push_back(mk(CMD_LOAD, 0, 16'hffff));
    pending_cmds.push_back(mk(CMD_STEP, 127, 16'hffff));
    pending_cmds.push_back(mk(CMD_TARGET, 0, 16'hffff));
    pending_cmds.push_back(mk(CMD_STEP, 0, 0));
    // green one unit above and below its target stays put
    pending_cmds.push_back(mk(CMD_LOAD, 0, 16'h0020));
    pending_cmds.push_back(mk(CMD_TARGET, 0, 16'h0000));
    pending_cmds.push_back(mk(CMD_STEP, 0, 0));
    pending_cmds.push_back(mk(CMD_LOAD, 0, 16'h0000));
    pending_cmds.push_back(mk(CMD_TARGET, 0, 16'h0020));
    pending_cmds.push_back(mk(CMD_STEP, 0, 0));
    // wheel segment edges and positions past the end of the wheel
    pending_cmds.push_back(mk(CMD_WHEEL, 0, 0));
    pending_cmds.push_back(mk(CMD_STEP, 0, 0));
    pending_cmds.push_back(mk(CMD_WHEEL, 31, 0));
    pending_cmds.push_back(mk(CMD_STEP, 0, 0));
    pending_cmds.push_back(mk(CMD_WHEEL, 32, 0));
    pending_cmds.push_back(mk(CMD_STEP, 0, 0));
    pending_cmds.push_back(mk(CMD_WHEEL, 63, 0));
    pending_cmds.push_back(mk(CMD_STEP, 0, 0));
    pending_cmds.push_back(mk(CMD_WHEEL, 64, 0));
    pending_cmds.push_back(mk(CMD_STEP, 0, 0));
    pending_cmds.push_back(mk(CMD_WHEEL, 95, 0));
    pending_cmds.push_back(mk(CMD_STEP, 0, 0));
    pending_cmds.push_back(mk(CMD_WHEEL, 127, 16'hffff));
    pending_cmds.push_back(mk(CMD_STEP, 127, 16'hffff));

    // mostly fade runs toward a fresh target, with some loose commands mixed in
    target_len = DIRECTED_LEN + RANDOM_LEN;
    while (pending_cmds.size() < target_len) begin
      if ($urandom_range(0, 4) == 0) begin
        pending_cmds.push_back(mk(rcf_cmd_t'(2'($urandom_range(0, 3))),
                                  $urandom_range(0, 127), rand_color()));
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          pending_cmds.push_back(mk(CMD_LOAD, $urandom_range(0, 127), rand_color()));
        end
        if ($urandom_range(0, 1) == 1) begin
          pending_cmds.push_back(mk(CMD_WHEEL, $urandom_range(0, 127), rand_color()));
        end else begin
          pending_cmds.push_back(mk(CMD_TARGET, $urandom_range(0, 127), rand_color()));
        end
        nsteps = $urandom_range(1, 40);
        repeat (nsteps) begin
          pending_cmds.push_back(mk(CMD_STEP, $urandom_range(0, 127), rand_color()));
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_shades.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_shades.size() > 0) begin
      log_failure($sformatf("%0d results never arrived", expected_shades.size()));
    end
    if (failures == 0) begin
      $display("rgb565_wheel_color_fader test passed");
    end else begin
      $display("rgb565_wheel_color_fader test failed");
    end
    $finish;
  end

endmodule
